// File: hdl/pwft_pkg.sv
// pwft_pkg: constants, codes and types for the pending write flush tracker
// used by pending_write_flush_tracker_core and tb_top
`timescale 1ns / 1ps
package pwft_pkg;
  localparam int StoreDepth = 32;
  localparam int SlotW      = $clog2(StoreDepth);
  localparam int CountW     = $clog2(StoreDepth + 1);
  localparam int SeqW       = 31;
  // entry word: written flag, size, txn, host, file, position
  localparam int EntryW     = 1 + 64 + 64 + 16 + 64 + 8;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_END     = 3'd1,
    ACT_WRITTEN = 3'd2,
    ACT_FLUSH   = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BAD_MSG     = 4'd1,
    ST_DUPLICATE   = 4'd2,
    ST_OUT_OF_SEQ  = 4'd3,
    ST_NOT_FOUND   = 4'd4,
    ST_WRITE_ORDER = 4'd5,
    ST_MISMATCH    = 4'd6,
    ST_BYTES_SET   = 4'd7,
    ST_FILES_SET   = 4'd8,
    ST_END_KNOWN   = 4'd9,
    ST_BAD_FLUSH   = 4'd10,
    ST_NOT_WRITTEN = 4'd11,
    ST_FULL        = 4'd12
  } status_t;

  localparam logic CfgMaxBytes = 1'b0;
  localparam logic CfgMaxFiles = 1'b1;

  typedef struct packed {
    logic        written;
    logic [63:0] size;
    logic [63:0] txn;
    logic [15:0] host;
    logic [63:0] file;
    logic [7:0]  pos;
  } entry_t;
endpackage

// File: hdl/pwft_ram.sv
// pwft_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module pwft_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/pending_write_flush_tracker_core.sv
// pending_write_flush_tracker_core: top level of the pending write flush tracker
// depends on pwft_pkg and pwft_ram
//
// usage: an item is transferred on in_* when start is high and busy is low.
// every item gives one or more results on out_*, each valid for exactly one
// cycle while out_valid is high; out_last marks the final one of an item.
// the receiver cannot stall; results are never held back.
// add, end, written and clear read the entry from the slot ram as the item is
// transferred, then check it and write it back in S_EXEC, which registers the
// result; busy drops in the cycle the result is shown, so the next item can be transferred then.
// a flush walks the slot ram one entry at a time through S_WALK_CHK and S_WALK_RD,
// set by the single read port of the slot ram, and stays busy until the walk stops
// on an entry not yet written or after its last entry; a rejected flush does not walk.
// configuration writes on cfg_* are taken at any time (cfg_ready is high)
// and must only happen while the block is idle.
// reset clears all control state and sets both thresholds to their defaults;
// the slot ram is not cleared, entries are only read while held.
`timescale 1ns / 1ps
module pending_write_flush_tracker_core
  import pwft_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_action,
  input  logic [SeqW-1:0]     in_fseq,
  input  logic [63:0]         in_file_size,
  input  logic [63:0]         in_transaction_id,
  input  logic [15:0]         in_host_id,
  input  logic [63:0]         in_file_id,
  input  logic [7:0]          in_position_code,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                out_valid,
  output logic [3:0]          out_status,
  output logic                out_carries_entry,
  output logic [SeqW-1:0]     out_fseq,
  output logic [63:0]         out_transaction_id,
  output logic [15:0]         out_host_id,
  output logic [63:0]         out_file_id,
  output logic [7:0]          out_position_code,
  output logic [63:0]         out_file_size,
  output logic                out_last,
  output logic [5:0]          out_pending_count
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK_RD, S_WALK_CHK} state_t;

  state_t            state_r;
  logic [2:0]        act_r;
  logic [SeqW-1:0]   seq_r;
  entry_t            in_r;
  logic [63:0]       max_bytes_r;
  logic [31:0]       max_files_r;
  logic [SeqW-1:0]   oldest_r, last_add_r, last_wr_r, end_seq_r, bpt_r, fpt_r;
  logic [CountW-1:0] count_r;
  logic [63:0]       ubytes_r;
  logic [31:0]       ufiles_r;

  logic              we;
  logic [SlotW-1:0]  waddr, raddr;
  entry_t            wdata, rd;

  pwft_ram #(.Width(EntryW), .Depth(StoreDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // combinational checks on the latched item
  logic [SeqW-1:0] diff;
  logic            held, bad, flush_ok;
  logic [SeqW-1:0] add_nxt_seq, wr_nxt_seq;
  logic [64:0]     bsum;
  logic [63:0]     bytes_nxt;
  logic [31:0]     files_nxt;
  logic            match;
  logic            add_ok;
  logic [5:0]      exec_pend;

  always_comb begin
    diff        = seq_r - oldest_r;
    held        = (count_r != '0) && (seq_r >= oldest_r) &&
                  ({{(SeqW-CountW){1'b0}}, count_r} > diff);
    bad         = (seq_r == '0) || (in_r.size == '0);
    add_nxt_seq = last_add_r + 1'b1;
    wr_nxt_seq  = last_wr_r + 1'b1;
    bsum        = {1'b0, ubytes_r} + {1'b0, in_r.size};
    bytes_nxt   = bsum[64] ? '1 : bsum[63:0];
    files_nxt   = (ufiles_r == '1) ? ufiles_r : ufiles_r + 1'b1;
    match       = (rd.txn == in_r.txn) && (rd.host == in_r.host) &&
                  (rd.file == in_r.file) && (rd.pos == in_r.pos) &&
                  (rd.size == in_r.size);
    flush_ok    = (seq_r != '0) &&
                  (((bpt_r == '0) && (fpt_r == '0) && (seq_r == end_seq_r)) ||
                   (seq_r == bpt_r) || (seq_r == fpt_r));
    add_ok      = (act_r == ACT_ADD) && !bad && !held &&
                  !(count_r != '0 && add_nxt_seq != seq_r) &&
                  (count_r < CountW'(StoreDepth));
    exec_pend   = 6'(count_r);
    if (add_ok) begin
      exec_pend = 6'(count_r + 1'b1);
    end
    if (act_r == ACT_CLEAR) begin
      exec_pend = '0;
    end
    raddr       = (state_r == S_IDLE) ? in_fseq[SlotW-1:0] :
                  (state_r == S_EXEC && act_r == ACT_FLUSH) ?
                  oldest_r[SlotW-1:0] : seq_r[SlotW-1:0];
    // the walk always reads the current oldest entry
    if (state_r == S_WALK_RD || state_r == S_WALK_CHK) begin
      raddr = oldest_r[SlotW-1:0];
    end
    we    = 1'b0;
    waddr = seq_r[SlotW-1:0];
    wdata = in_r;
    if (state_r == S_EXEC && add_ok) begin
      we            = 1'b1;
      wdata.written = 1'b0;
    end
    if (state_r == S_EXEC && act_r == ACT_WRITTEN && !bad && held &&
        !(last_wr_r != '0 && wr_nxt_seq != seq_r) && match) begin
      we            = 1'b1;
      wdata.written = 1'b1;
    end
  end

  task automatic emit(input status_t st, input logic lst);
    out_valid         <= 1'b1;
    out_status        <= st;
    out_carries_entry <= 1'b0;
    out_fseq          <= '0;
    out_transaction_id <= '0;
    out_host_id       <= '0;
    out_file_id       <= '0;
    out_position_code <= '0;
    out_file_size     <= '0;
    out_last          <= lst;
  endtask

  logic released_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_bytes_r <= 64'd8589934592;
      max_files_r <= 32'd1000;
      oldest_r    <= '0; last_add_r <= '0; last_wr_r <= '0; end_seq_r <= '0;
      bpt_r       <= '0; fpt_r <= '0; count_r <= '0;
      ubytes_r    <= '0; ufiles_r <= '0;
      out_valid   <= 1'b0;
      released_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgMaxBytes: max_bytes_r <= cfg_data;
          CfgMaxFiles: max_files_r <= cfg_data[31:0];
          default:     ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (start) begin
            act_r        <= in_action;
            seq_r        <= in_fseq;
            in_r.written <= 1'b0;
            in_r.size    <= in_file_size;
            in_r.txn     <= in_transaction_id;
            in_r.host    <= in_host_id;
            in_r.file    <= in_file_id;
            in_r.pos     <= in_position_code;
            state_r      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r           <= (act_r == ACT_FLUSH && flush_ok) ? S_WALK_CHK : S_IDLE;
          out_pending_count <= exec_pend;
          priority case (act_r)
            ACT_ADD: begin
              if (bad) emit(ST_BAD_MSG, 1'b1);
              else if (held) emit(ST_DUPLICATE, 1'b1);
              else if (count_r != '0 && add_nxt_seq != seq_r)
                emit(ST_OUT_OF_SEQ, 1'b1);
              else if (count_r >= CountW'(StoreDepth)) emit(ST_FULL, 1'b1);
              else begin
                if (count_r == '0) oldest_r <= seq_r;
                count_r           <= count_r + 1'b1;
                last_add_r        <= seq_r;
                emit(ST_OK, 1'b1);
              end
            end
            ACT_END: begin
              if (end_seq_r != '0) emit(ST_END_KNOWN, 1'b1);
              else begin
                end_seq_r <= last_add_r;
                emit(ST_OK, 1'b1);
              end
            end
            ACT_WRITTEN: begin
              if (bad) emit(ST_BAD_MSG, 1'b1);
              else if (!held) emit(ST_NOT_FOUND, 1'b1);
              else if (last_wr_r != '0 && wr_nxt_seq != seq_r)
                emit(ST_WRITE_ORDER, 1'b1);
              else if (!match) emit(ST_MISMATCH, 1'b1);
              else begin
                last_wr_r <= seq_r;
                ubytes_r  <= bytes_nxt;
                ufiles_r  <= files_nxt;
                if (max_bytes_r <= bytes_nxt && bpt_r != '0) emit(ST_BYTES_SET, 1'b1);
                else begin
                  if (max_bytes_r <= bytes_nxt) bpt_r <= seq_r;
                  if (max_files_r <= files_nxt) begin
                    if (fpt_r != '0) emit(ST_FILES_SET, 1'b1);
                    else begin
                      fpt_r <= seq_r;
                      emit(ST_OK, 1'b1);
                    end
                  end else emit(ST_OK, 1'b1);
                end
              end
            end
            ACT_FLUSH: begin
              if (!flush_ok) emit(ST_BAD_FLUSH, 1'b1);
              else begin
                ubytes_r   <= '0; ufiles_r <= '0; bpt_r <= '0; fpt_r <= '0;
                released_r <= 1'b0;
                out_valid  <= 1'b0;
              end
            end
            ACT_CLEAR: begin
              oldest_r <= '0; last_add_r <= '0; last_wr_r <= '0; end_seq_r <= '0;
              bpt_r    <= '0; fpt_r <= '0; count_r <= '0;
              ubytes_r <= '0; ufiles_r <= '0;
              emit(ST_OK, 1'b1);
            end
            default: emit(ST_BAD_MSG, 1'b1);
          endcase
        end
        S_WALK_RD: begin
          out_valid <= 1'b0;
          state_r   <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          // rd holds the slot of oldest_r here
          if (count_r != '0 && oldest_r <= seq_r) begin
            if (!rd.written) begin
              emit(ST_NOT_WRITTEN, 1'b1);
              out_pending_count <= 6'(count_r);
              state_r <= S_IDLE;
            end else begin
              out_valid          <= 1'b1;
              out_status         <= ST_OK;
              out_carries_entry  <= 1'b1;
              out_fseq           <= oldest_r;
              out_transaction_id <= rd.txn;
              out_host_id        <= rd.host;
              out_file_id        <= rd.file;
              out_position_code  <= rd.pos;
              out_file_size      <= rd.size;
              out_pending_count  <= 6'(count_r - 1'b1);
              // last when the next entry is beyond the point, none remain or the sequence number would wrap
              out_last           <= (count_r == CountW'(1)) || (oldest_r == seq_r) ||
                                    (oldest_r == '1);
              if ((count_r == CountW'(1)) || (oldest_r == seq_r) || (oldest_r == '1))
                state_r <= S_IDLE;
              else
                state_r <= S_WALK_RD;
              count_r    <= count_r - 1'b1;
              oldest_r   <= oldest_r + 1'b1;
              released_r <= 1'b1;
            end
          end else begin
            if (!released_r) begin
              emit(ST_OK, 1'b1);
              out_pending_count <= 6'(count_r);
            end else begin
              out_valid <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for pending_write_flush_tracker_core
// depends on pwft_pkg and the core; predicts every result and checks it on out_*
`timescale 1ns / 1ps
module tb_top;
  import pwft_pkg::*;

  typedef struct packed {
    logic [2:0]  act;
    logic [30:0] seq;
    logic [63:0] size;
    logic [63:0] txn;
    logic [15:0] host;
    logic [63:0] file;
    logic [7:0]  pos;
  } file_req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        carries;
    logic [30:0] seq;
    logic [63:0] txn;
    logic [15:0] host;
    logic [63:0] file;
    logic [7:0]  pos;
    logic [63:0] size;
    logic        last;
    logic [5:0]  pend;
  } tracker_resp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_action;
  logic [30:0] in_fseq;
  logic [63:0] in_file_size, in_transaction_id, in_file_id;
  logic [15:0] in_host_id;
  logic [7:0] in_position_code;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;
  logic out_valid, out_carries_entry, out_last;
  logic [3:0] out_status;
  logic [30:0] out_fseq;
  logic [63:0] out_transaction_id, out_file_id, out_file_size;
  logic [15:0] out_host_id;
  logic [7:0] out_position_code;
  logic [5:0] out_pending_count;

  always #5 clk = ~clk;

  pending_write_flush_tracker_core u_dut (.*);

  // tracker copy kept by the testbench
  logic [63:0] trk_max_bytes;
  logic [31:0] trk_max_files;
  logic [30:0] trk_oldest, trk_last_add, trk_last_wr, trk_end, trk_bytes_pt, trk_files_pt;
  int          trk_count;
  logic [63:0] trk_bytes;
  logic [31:0] trk_files;
  logic        slot_done[StoreDepth];
  file_req_t   slot_req[StoreDepth];

  tracker_resp_t result_q[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic void clear_tracker();
    trk_oldest = '0; trk_count = 0; trk_last_add = '0; trk_last_wr = '0;
    trk_end = '0; trk_bytes_pt = '0; trk_files_pt = '0;
    trk_bytes = '0; trk_files = '0;
  endfunction

  function automatic bit is_held(logic [30:0] seq);
    return trk_count != 0 && seq >= trk_oldest && (seq - trk_oldest) < trk_count;
  endfunction

  function automatic void expect_result(logic [3:0] status, int slot, logic [30:0] seq,
                                        logic last);
    tracker_resp_t r;
    r = '0;
    r.status = status;
    if (slot >= 0) begin
      r.carries = 1'b1;
      r.seq = seq;
      r.txn = slot_req[slot].txn;
      r.host = slot_req[slot].host;
      r.file = slot_req[slot].file;
      r.pos = slot_req[slot].pos;
      r.size = slot_req[slot].size;
    end
    r.last = last;
    r.pend = trk_count[5:0];
    result_q.insert(result_q.size(), r);
  endfunction

  function automatic logic [3:0] add_status(file_req_t r);
    if (r.seq == 0 || r.size == 0) return ST_BAD_MSG;
    if (is_held(r.seq)) return ST_DUPLICATE;
    if (trk_count != 0 && trk_last_add + 31'd1 != r.seq) return ST_OUT_OF_SEQ;
    if (trk_count >= StoreDepth) return ST_FULL;
    slot_done[r.seq[4:0]] = 1'b0;
    slot_req[r.seq[4:0]] = r;
    if (trk_count == 0) trk_oldest = r.seq;
    trk_count++;
    trk_last_add = r.seq;
    return ST_OK;
  endfunction

  function automatic logic [3:0] written_status(file_req_t r);
    file_req_t h;
    if (r.seq == 0 || r.size == 0) return ST_BAD_MSG;
    if (!is_held(r.seq)) return ST_NOT_FOUND;
    if (trk_last_wr != 0 && trk_last_wr + 31'd1 != r.seq) return ST_WRITE_ORDER;
    h = slot_req[r.seq[4:0]];
    if (h.txn != r.txn || h.host != r.host || h.file != r.file || h.pos != r.pos ||
        h.size != r.size) return ST_MISMATCH;
    slot_done[r.seq[4:0]] = 1'b1;
    trk_last_wr = r.seq;
    if (trk_bytes > ~r.size) trk_bytes = '1;
    else trk_bytes += r.size;
    if (trk_files != '1) trk_files++;
    if (trk_max_bytes <= trk_bytes) begin
      if (trk_bytes_pt != 0) return ST_BYTES_SET;
      trk_bytes_pt = r.seq;
    end
    if (trk_max_files <= trk_files) begin
      if (trk_files_pt != 0) return ST_FILES_SET;
      trk_files_pt = r.seq;
    end
    return ST_OK;
  endfunction

  function automatic void predict_flush(logic [30:0] point);
    bit ok;
    int released;
    ok = 0;
    released = 0;
    if (point != 0) begin
      if (trk_bytes_pt == 0 && trk_files_pt == 0 && point == trk_end) ok = 1;
      else if (point == trk_bytes_pt || point == trk_files_pt) ok = 1;
    end
    if (!ok) begin
      expect_result(ST_BAD_FLUSH, -1, '0, 1'b1);
      return;
    end
    trk_bytes = '0; trk_files = '0; trk_bytes_pt = '0; trk_files_pt = '0;
    while (trk_count != 0 && trk_oldest <= point) begin
      if (!slot_done[trk_oldest[4:0]]) begin
        expect_result(ST_NOT_WRITTEN, -1, '0, 1'b1);
        return;
      end
      trk_count--;
      // last only when the walk stops normally after this entry
      expect_result(ST_OK, trk_oldest[4:0], trk_oldest,
                    !(trk_count != 0 && trk_oldest + 31'd1 <= point));
      released++;
      trk_oldest = trk_oldest + 31'd1;
    end
    if (released == 0) expect_result(ST_OK, -1, '0, 1'b1);
  endfunction

  function automatic void predict_tracker(file_req_t r);
    case (r.act)
      ACT_ADD:     expect_result(add_status(r), -1, '0, 1'b1);
      ACT_WRITTEN: expect_result(written_status(r), -1, '0, 1'b1);
      ACT_FLUSH:   predict_flush(r.seq);
      ACT_END: begin
        if (trk_end != 0) begin
          expect_result(ST_END_KNOWN, -1, '0, 1'b1);
        end else begin
          trk_end = trk_last_add;
          expect_result(ST_OK, -1, '0, 1'b1);
        end
      end
      ACT_CLEAR: begin
        clear_tracker();
        expect_result(ST_OK, -1, '0, 1'b1);
      end
      default: expect_result(ST_BAD_MSG, -1, '0, 1'b1);
    endcase
  endfunction

  // start stays high between back-to-back transfers
  task automatic send_req(file_req_t r);
    in_action <= r.act;
    in_fseq <= r.seq;
    in_file_size <= r.size;
    in_transaction_id <= r.txn;
    in_host_id <= r.host;
    in_file_id <= r.file;
    in_position_code <= r.pos;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_tracker(r);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CfgMaxBytes) trk_max_bytes = val;
    else trk_max_files = val[31:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic file_req_t mk(logic [2:0] act, logic [30:0] seq, logic [63:0] size,
                                   logic [63:0] fill);
    file_req_t r;
    r.act = act; r.seq = seq; r.size = size;
    r.txn = fill; r.host = fill[15:0]; r.file = fill; r.pos = fill[7:0];
    return r;
  endfunction

  function automatic file_req_t random_req();
    file_req_t r;
    int p;
    r.txn = {$urandom, $urandom};
    r.host = 16'($urandom);
    r.file = {$urandom, $urandom};
    r.pos = 8'($urandom);
    r.size = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
             64'($urandom_range(1, 5000));
    r.act = ACT_ADD;
    r.seq = '0;
    p = $urandom_range(0, 99);
    if (p < 72 && p >= 40) begin
      r.seq = (trk_last_wr != 0) ? trk_last_wr + 31'd1 : trk_oldest;
      if (is_held(r.seq)) begin
        r = slot_req[r.seq[4:0]];
        r.act = ACT_WRITTEN;
        if ($urandom_range(0, 9) == 0) r.txn[$urandom_range(0, 63)] ^= 1'b1;
        return r;
      end
      p = 0;
    end
    if (p < 40) begin
      if (trk_count == 0) r.seq = 31'($urandom_range(1, 32'h7FFF_FFFF));
      else r.seq = trk_last_add + 31'd1;
    end else if (p < 84) begin
      r.act = ACT_FLUSH;
      r.seq = trk_bytes_pt != 0 ? trk_bytes_pt : trk_files_pt != 0 ? trk_files_pt : trk_end;
      if ($urandom_range(0, 4) == 0) r.seq = trk_last_wr;
      if (r.seq == 0) r.act = ACT_END;
    end else if (p < 89) begin
      r.act = ACT_END;
    end else if (p < 94) begin
      r.act = ACT_CLEAR;
    end else begin
      r.act = 3'($urandom_range(0, 7));
      r.seq = 31'($urandom);
      if ($urandom_range(0, 3) == 0) r.size = '0;
    end
    return r;
  endfunction

  task automatic test_error_codes();
    file_req_t w;
    send_req(mk(3'd5, 31'd1, 64'd1, '0));
    send_req(mk(3'd7, '1, '1, '1));
    send_req(mk(ACT_ADD, '0, 64'd1, '0));
    send_req(mk(ACT_ADD, 31'd1, '0, '0));
    send_req(mk(ACT_ADD, 31'h7FFF_FFFE, '1, '1));
    send_req(mk(ACT_ADD, 31'h7FFF_FFFE, '1, '1));
    send_req(mk(ACT_ADD, 31'd5, 64'd1, '1));
    send_req(mk(ACT_ADD, 31'h7FFF_FFFF, '1, 64'h5A5A_A5A5_0F0F_F0F0));
    send_req(mk(ACT_WRITTEN, 31'd100, 64'd1, '0));
    send_req(mk(ACT_WRITTEN, 31'h7FFF_FFFE, '1, '1));
    send_req(mk(ACT_WRITTEN, 31'h7FFF_FFFE, '1, '1));
    w = mk(ACT_WRITTEN, 31'h7FFF_FFFF, '1, 64'h5A5A_A5A5_0F0F_F0F0);
    w.host ^= 16'h8000;
    send_req(w);
    // second full-size file saturates the byte total with the point already set
    send_req(mk(ACT_WRITTEN, 31'h7FFF_FFFF, '1, 64'h5A5A_A5A5_0F0F_F0F0));
    send_req(mk(ACT_FLUSH, 31'd3, 64'd1, '0));
    send_req(mk(ACT_FLUSH, '0, 64'd1, '0));
    send_req(mk(ACT_END, '0, 64'd1, '0));
    send_req(mk(ACT_END, '0, 64'd1, '0));
    send_req(mk(ACT_FLUSH, 31'h7FFF_FFFE, 64'd1, '0));
    send_req(mk(ACT_FLUSH, 31'h7FFF_FFFF, 64'd1, '0));
    send_req(mk(ACT_FLUSH, 31'h7FFF_FFFF, 64'd1, '0));
    send_req(mk(ACT_CLEAR, '0, 64'd1, '0));
    send_req(mk(ACT_ADD, 31'd10, 64'd7, 64'd3));
    send_req(mk(ACT_ADD, 31'd11, 64'd8, 64'd4));
    send_req(mk(ACT_WRITTEN, 31'd10, 64'd7, 64'd3));
    send_req(mk(ACT_END, '0, 64'd1, '0));
    send_req(mk(ACT_FLUSH, 31'd11, 64'd1, '0));
    send_req(mk(ACT_CLEAR, '0, 64'd1, '0));
  endtask

  task automatic test_store_full();
    for (int i = 1; i <= StoreDepth + 1; i++) send_req(mk(ACT_ADD, 31'(i), 64'd1, '0));
    send_req(mk(ACT_CLEAR, '0, 64'd1, '0));
  endtask

  task automatic test_thresholds();
    drain();
    write_cfg(CfgMaxBytes, 64'd2);
    write_cfg(CfgMaxFiles, 64'd1);
    for (int i = 1; i <= 3; i++) send_req(mk(ACT_ADD, 31'(i), 64'd1, 64'd9));
    for (int i = 1; i <= 3; i++) send_req(mk(ACT_WRITTEN, 31'(i), 64'd1, 64'd9));
    send_req(mk(ACT_FLUSH, 31'd1, 64'd1, '0));
    send_req(mk(ACT_END, '0, 64'd1, '0));
    send_req(mk(ACT_FLUSH, 31'd3, 64'd1, '0));
    send_req(mk(ACT_CLEAR, '0, 64'd1, '0));
  endtask

  task automatic test_random_phase(int pct, int n, logic [63:0] max_bytes,
                                   logic [31:0] max_files, bit pause);
    drain();
    write_cfg(CfgMaxBytes, max_bytes);
    write_cfg(CfgMaxFiles, {32'd0, max_files});
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      send_req(random_req());
      if (pause && i == n / 2) drain();
    end
    idle_pct = 0;
  endtask

  always @(posedge clk) begin
    tracker_resp_t got, want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got = {out_status, out_carries_entry, out_fseq, out_transaction_id, out_host_id,
             out_file_id, out_position_code, out_file_size, out_last, out_pending_count};
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= '0; in_fseq <= '0; in_file_size <= '0; in_transaction_id <= '0;
    in_host_id <= '0; in_file_id <= '0; in_position_code <= '0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    trk_max_bytes = 64'd8589934592;
    trk_max_files = 32'd1000;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_error_codes();
    test_store_full();
    test_thresholds();
    test_random_phase(0, 48, 64'd8589934592, 32'd1000, 1'b0);
    test_random_phase(57, 48, '0, '0, 1'b1);
    test_random_phase(0, 48, '1, '1, 1'b0);
    test_random_phase(10, 48, 64'd20000, $urandom_range(1, 8), 1'b0);
    drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
